// ===== design/sitpda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitpda_pkg
// Shared types and constants for the signed integer to padded decimal ASCII
// converter.
// ----------------------------------------------------------------------------
package sitpda_pkg;

   localparam int DATA_W        = 32;   // input integer width
   localparam int NDIG          = 10;   // BCD digits of a 32-bit magnitude
   localparam int DIG_W         = 4;
   localparam int NDIG_W        = 4;    // holds 1 to 10
   localparam int CHAR_W        = 6;
   localparam int CSR_W         = 6;
   localparam int CMP_W         = 7;    // holds any min_width and any MAX_WIDTH
   localparam int MAX_WIDTH_DEF = 32;

   localparam logic [CSR_W-1:0]  MIN_WIDTH_RST = 6'd12;
   localparam logic [CHAR_W-1:0] CHR_ZERO      = 6'd48;
   localparam logic [CHAR_W-1:0] CHR_MINUS     = 6'd45;
   localparam logic [CHAR_W-1:0] CHR_SPACE     = 6'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;   // capture a request and start conversion
      logic step;   // one double-dabble shift
      logic size;   // work out digit count and character count
      logic emit;   // load one character into the output register
   } cmd_type;

   typedef struct packed {
      logic conv_last;  // the current step is the final shift
      logic out_free;   // output register can take a character this cycle
      logic rem_zero;   // the next character is the final one
   } status_type;

endpackage

// ===== design/sitpda_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitpda_ctrl
// Sequencer: accepts a request, runs the conversion, sizes the text and
// paces character output.
// ----------------------------------------------------------------------------
module sitpda_ctrl
   import sitpda_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // No request is taken while reset is held.
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (status.conv_last) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.rem_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/sitpda_dp.sv =====
// ----------------------------------------------------------------------------
// sitpda_dp
// Datapath: magnitude capture, double-dabble BCD shifter, text sizing,
// character selection and the output register.
// ----------------------------------------------------------------------------
module sitpda_dp
   import sitpda_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [DATA_W-1:0] req_value,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [CHAR_W-1:0] rsp_char,
   output logic              rsp_last
);

   localparam int RW  = $clog2(MAX_WIDTH);
   localparam int CNW = $clog2(DATA_W);
   localparam int BW  = NDIG * DIG_W;

   logic [CSR_W-1:0]  min_width_ff;
   logic [DATA_W-1:0] mag_ff;
   logic              neg_ff;
   logic [BW-1:0]     bcd_ff;
   logic [CNW-1:0]    cnt_ff;
   logic [NDIG_W-1:0] ndig_ff;
   logic [RW-1:0]     rem_ff;
   logic              valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;

   logic [BW-1:0]     adj;
   logic [NDIG_W-1:0] ndig_in;
   logic [CMP_W-1:0]  width_sat;
   logic [CMP_W-1:0]  textlen;
   logic [CMP_W-1:0]  total;
   logic [CHAR_W-1:0] char_in;
   logic [DIG_W-1:0]  digit;
   logic              out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_WIDTH_RST;
      end else if (csr_we) begin
         min_width_ff <= csr_wdata;
      end
   end

   // Add three to every digit of five or more before each shift.
   always_comb begin
      for (int k = 0; k < NDIG; k++) begin
         if (bcd_ff[k*DIG_W +: DIG_W] >= 4'd5) begin
            adj[k*DIG_W +: DIG_W] = bcd_ff[k*DIG_W +: DIG_W] + 4'd3;
         end else begin
            adj[k*DIG_W +: DIG_W] = bcd_ff[k*DIG_W +: DIG_W];
         end
      end
   end

   // Significant digit count: position of the highest nonzero digit, at least one.
   always_comb begin
      ndig_in = NDIG_W'(1);
      for (int k = 1; k < NDIG; k++) begin
         if (bcd_ff[k*DIG_W +: DIG_W] != '0) begin
            ndig_in = NDIG_W'(k + 1);
         end
      end
   end

   always_comb begin
      if ({1'b0, min_width_ff} > CMP_W'(MAX_WIDTH)) begin
         width_sat = CMP_W'(MAX_WIDTH);
      end else begin
         width_sat = CMP_W'(min_width_ff);
      end
      textlen = CMP_W'(ndig_in) + CMP_W'(neg_ff);
      total   = (width_sat > textlen) ? width_sat : textlen;
   end

   // The remaining count doubles as the character position from the right.
   assign digit = bcd_ff[rem_ff[NDIG_W-1:0]*DIG_W +: DIG_W];

   always_comb begin
      if (rem_ff < RW'(ndig_ff)) begin
         char_in = CHR_ZERO + CHAR_W'(digit);
      end else if (neg_ff && (rem_ff == RW'(ndig_ff))) begin
         char_in = CHR_MINUS;
      end else begin
         char_in = CHR_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value[DATA_W-1];
         mag_ff <= req_value[DATA_W-1] ? (DATA_W'(0) - req_value) : req_value;
         bcd_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         bcd_ff <= {adj[BW-2:0], mag_ff[DATA_W-1]};
         mag_ff <= {mag_ff[DATA_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + CNW'(1);
      end
      if (cmd.size) begin
         ndig_ff <= ndig_in;
         rem_ff  <= RW'(total - CMP_W'(1));
      end else if (cmd.emit) begin
         rem_ff  <= rem_ff - RW'(1);
      end
      if (cmd.emit) begin
         char_ff <= char_in;
         last_ff <= (rem_ff == '0);
      end
   end

   assign out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign status.conv_last = (cnt_ff == CNW'(DATA_W - 1));
   assign status.out_free  = out_free;
   assign status.rem_zero  = (rem_ff == '0);

   assign rsp_tvalid = valid_ff;
   assign rsp_char   = char_ff;
   assign rsp_last   = last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("character loaded while output register was still held");

   a_char_code: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (char_ff == CHR_SPACE || char_ff == CHR_MINUS ||
                    (char_ff >= CHR_ZERO && char_ff <= CHR_ZERO + 6'd9)))
      else $error("output character is not a space, minus or digit");

   a_size_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.size |=> (ndig_ff >= NDIG_W'(1) && ndig_ff <= NDIG_W'(NDIG) &&
                    (CMP_W'(rem_ff) + CMP_W'(1) >= CMP_W'(ndig_ff) + CMP_W'(neg_ff))))
      else $error("character count shorter than the text");

endmodule

// ===== design/signed_int_to_padded_decimal_ascii_core.sv =====
// After a request is accepted the block runs 32 double-dabble shifts, one per input bit,
// then a sizing step, and then loads the first character into the output register.
// An item gives N characters, N = max(text length, min(min_width, MAX_WIDTH)), one
// per cycle while rsp_tready stays high; requests are taken one at a time.
// Reset clears the sequencer and output valid and sets min_width to 12.
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_ascii_core
// Converts a 32-bit signed integer to right-justified decimal ASCII text,
// one character per response, with tlast on the final character.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_ascii_core
   import sitpda_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [31:0] value
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [5:0] text_char, [7:6] zero
   output logic              rsp_tlast,   // last_char
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_wdata    // min_width
);

   cmd_type           cmd;
   status_type        status;
   logic [CHAR_W-1:0] rsp_char;

   sitpda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sitpda_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_char};

endmodule

// ===== bench/signed_int_to_padded_decimal_ascii_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_ascii_core_tb
// Sends signed integers into the converter and checks every returned ASCII
// character and its last flag against a text predictor that tracks the
// min_width register. The run sweeps several widths and three idle patterns.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_ascii_core_tb;
   import sitpda_pkg::*;

   localparam int LIMIT_CYCLES  = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;

   typedef struct {
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
   } char_rec_type;

   // Predicts the character stream of each request and matches it against
   // the characters that come back.
   class decimal_text_book;
      int unsigned  width_reg;
      char_rec_type owed_chars[$];
      int           errors;

      function new();
         width_reg = MIN_WIDTH_RST;
         errors    = 0;
      endfunction

      function void set_width(logic [CSR_W-1:0] w);
         width_reg = w;
      endfunction

      function int owed();
         return owed_chars.size();
      endfunction

      function void take_value(logic [DATA_W-1:0] value);
         logic              negative;
         logic [DATA_W-1:0] mag;
         logic [DIG_W-1:0]  digs[NDIG];
         int                ndig;
         int                textlen;
         int                eff;
         int                total;
         int                k;
         char_rec_type      rec;
         negative = value[DATA_W-1];
         // The magnitude is taken unsigned, so the most negative value works.
         mag  = negative ? (32'd0 - value) : value;
         ndig = 0;
         do begin
            digs[ndig] = DIG_W'(mag % 10);
            ndig++;
            mag = mag / 10;
         end while (mag != 0);
         textlen = ndig + (negative ? 1 : 0);
         eff     = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
         total   = (eff > textlen) ? eff : textlen;
         rec.last_char = 1'b0;
         for (k = 0; k < total - textlen; k++) begin
            rec.text_char = CHR_SPACE;
            owed_chars.push_back(rec);
         end
         if (negative) begin
            rec.text_char = CHR_MINUS;
            owed_chars.push_back(rec);
         end
         for (k = ndig - 1; k >= 0; k--) begin
            rec.text_char = CHR_ZERO + digs[k];
            rec.last_char = (k == 0);
            owed_chars.push_back(rec);
         end
      endfunction

      function void match_char(logic [7:0] data, logic last);
         char_rec_type want;
         if (owed_chars.size() == 0) begin
            $display("%0t: unexpected character, actual %h last %b", $time, data, last);
            errors++;
            return;
         end
         want = owed_chars.pop_front();
         if (data !== {2'b00, want.text_char}) begin
            $display("%0t: text_char mismatch, expected %h actual %h",
                     $time, {2'b00, want.text_char}, data);
            errors++;
         end
         if (last !== want.last_char) begin
            $display("%0t: last_char mismatch, expected %b actual %b",
                     $time, want.last_char, last);
            errors++;
         end
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // [31:0] value
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;         // [5:0] text_char, [7:6] zero
   logic              rsp_tlast;         // last_char
   logic              csr_we     = 1'b0;
   logic [CSR_W-1:0]  csr_wdata  = '0;   // min_width

   decimal_text_book book;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_left   = 0;
   int cycle_count = 0;

   signed_int_to_padded_decimal_ascii_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // These processes see the values from before the edge, as the block does.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) book.take_value(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) book.match_char(rsp_tdata, rsp_tlast);
      if (!reset && csr_we) book.set_width(csr_wdata);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("signed_int_to_padded_decimal_ascii_core_tb: FAIL");
         $finish;
      end
   end

   task automatic send_value(input logic [DATA_W-1:0] v);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.owed() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_min_width(input logic [CSR_W-1:0] w);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mixes full-range words, corner values, short numbers and values next to powers of ten.
   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] v;
      int unsigned       mode;
      int unsigned       tens;
      int                p;
      mode = $urandom_range(9);
      if (mode <= 3) begin
         v = $urandom();
      end else if (mode == 8) begin
         case ($urandom_range(4))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h8000_0001;
            3:       v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end else begin
         if (mode <= 5) begin
            v = $urandom_range(999);
         end else if (mode <= 7) begin
            p    = $urandom_range(9);
            tens = 1;
            repeat (p) tens = tens * 10;
            v = tens - $urandom_range(1);
         end else begin
            v = $urandom_range(99999);
         end
         if ($urandom_range(1)) v = 32'd0 - v;
      end
      return v;
   endfunction

   initial begin
      int m;
      int b;
      int k;
      int tx_pct[3];
      int rx_pct[3];
      logic [CSR_W-1:0] w;
      tx_pct = '{8, 50, 0};
      rx_pct = '{50, 8, 0};
      book = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset width of 12.
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd10);
      send_value(-32'sd9);
      send_value(32'd1000000000);
      send_value(-32'sd1000000000);
      // No padding at all.
      set_min_width(6'd0);
      send_value(32'd0);
      send_value(32'h8000_0000);
      send_value(32'd5);
      send_value(-32'sd12345);
      set_min_width(6'd1);
      send_value(32'd7);
      send_value(-32'sd7);
      // Width equal to the longest text, and one above a ten-digit value.
      set_min_width(6'd11);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      set_min_width(6'd32);
      send_value(32'hFFFF_FFFF);
      send_value(32'd123);
      // Widths above the maximum saturate.
      set_min_width(6'd33);
      send_value(32'd42);
      set_min_width(6'd63);
      send_value(32'h8000_0000);

      for (m = 0; m < 3; m++) begin
         tx_idle_pct = tx_pct[m];
         rx_idle_pct = rx_pct[m];
         for (b = 0; b < 4; b++) begin
            if (b == 0) begin
               case (m)
                  0:       w = 6'd0;
                  1:       w = 6'd32;
                  default: w = 6'd63;
               endcase
            end else if ($urandom_range(1)) begin
               w = CSR_W'($urandom_range(15));
            end else begin
               w = CSR_W'($urandom_range(63));
            end
            set_min_width(w);
            for (k = 0; k < 17; k++) send_value(pick_value());
            if (b == 1) wait_drained();
         end
      end

      // Hold the response side off so the block backs up into its input.
      wait_drained();
      hold_left = HOLD_CYCLES;
      for (k = 0; k < 6; k++) send_value(pick_value());

      wait_drained();
      if (book.errors == 0) begin
         $display("signed_int_to_padded_decimal_ascii_core_tb: PASS");
      end else begin
         $display("signed_int_to_padded_decimal_ascii_core_tb: FAIL");
      end
      $finish;
   end

endmodule
